// ----- src/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset masked
`define LACP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, reset masked
`define LACP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- src/lacp_pkg.sv -----
`timescale 1ns / 1ps

package lacp_pkg;

    localparam int MAX_ATOMS_DEF     = 1024;
    localparam int MAX_HYDROGENS_DEF = 1024;

    localparam int CFG_W = 31;
    localparam int IDX_W = 10;

    // register indexes
    localparam logic [1:0] CFG_REDUCE   = 2'd0;
    localparam logic [1:0] CFG_CUTOFF   = 2'd1;
    localparam logic [1:0] CFG_FRACTION = 2'd2;
    localparam logic [1:0] CFG_CSTEP    = 2'd3;

    localparam logic        RESET_REDUCE   = 1'b0;
    localparam logic [30:0] RESET_CUTOFF   = 31'd196608;
    localparam logic [15:0] RESET_FRACTION = 16'd34210;
    localparam logic [30:0] RESET_CSTEP    = 31'd24357;

    // transaction kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_FETCH = 1'b1;

    // record kinds
    localparam logic [1:0] REC_CORE  = 2'd0;
    localparam logic [1:0] REC_HYD   = 2'd1;
    localparam logic [1:0] REC_OUTER = 2'd2;

    typedef struct packed {
        logic               kind;
        logic               in_core;
        logic               is_boundary;
        logic               is_partner;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] charge_in;
        logic               last_atom;
    } t_in;

    typedef struct packed {
        logic [1:0]         record_kind;
        logic [IDX_W-1:0]   atom_index;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_charge;
        logic               last_record;
        logic               hydrogen_dropped;
    } t_out;

endpackage

// ----- src/link_atom_cutoff_placer.sv -----
`timescale 1ns / 1ps

// Link atom placer. A load transaction (kind 0) stores one atom without leaving
// idle, so loads go back to back. The first fetch after the last atom runs the
// neighbor pass out of the atom memories: a read and a write per atom build the
// core list, then every core atom is looked up and the atoms scanned, with a check
// per atom, a squaring and compare per flagged candidate (one 32x32 squaring per
// axis) and a place step per hydrogen in range. Each later fetch reads out the next
// record, skipping core-list atoms, all paced by the registered memory reads. busy
// is high meanwhile. A result shows for exactly one cycle on o_strobe; the
// receiver cannot stall it, so results must be taken as they come.
module link_atom_cutoff_placer #(
    parameter int MAX_ATOMS     = lacp_pkg::MAX_ATOMS_DEF,
    parameter int MAX_HYDROGENS = lacp_pkg::MAX_HYDROGENS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  lacp_pkg::t_in              i_item,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_idx,
    input  logic [lacp_pkg::CFG_W-1:0] i_cfg_data,
    output logic                       o_strobe,
    output lacp_pkg::t_out             o_result
);

    localparam int AW  = $clog2(MAX_ATOMS);
    localparam int CW  = $clog2(MAX_ATOMS + 1);
    localparam int HW  = (MAX_HYDROGENS > 1) ? $clog2(MAX_HYDROGENS) : 1;
    localparam int HCW = $clog2(MAX_HYDROGENS + 1);
    localparam int EW  = $clog2(MAX_ATOMS + MAX_HYDROGENS + 1);

    typedef struct packed {
        logic        core;
        logic        bnd;
        logic        part;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } t_atom;

    typedef struct packed {
        logic [AW-1:0] owner;
        logic [31:0]   x;
        logic [31:0]   y;
        logic [31:0]   z;
    } t_hyd;

    typedef enum logic [1:0] {PH_LOAD, PH_READY, PH_EMIT, PH_DONE} t_phase;

    typedef enum logic [4:0] {
        S_IDLE, S_P1_RD, S_P1_WR, S_O_START, S_O_RD, S_O_C, S_O_CD,
        S_I_RD, S_I_CHK, S_SQ, S_ACC, S_CMP, S_PLACE, S_NEXT,
        S_E_START, S_E_C1, S_E_C2, S_E_H, S_E_SR, S_E_SC
    } t_state;

    function automatic logic [31:0] f_absdiff(logic [31:0] a, logic [31:0] b);
        logic [32:0] d;
        d = {a[31], a} - {b[31], b};
        return d[32] ? 32'(~d + 33'd1) : d[31:0];
    endfunction

    function automatic logic [31:0] f_place(logic [31:0] core, logic [31:0] partner,
                                            logic [15:0] frac);
        logic [32:0] d;
        logic [31:0] m;
        logic [47:0] prod;
        logic [31:0] off;
        logic [32:0] s;
        d    = {partner[31], partner} - {core[31], core};
        m    = d[32] ? 32'(~d + 33'd1) : d[31:0];
        prod = {16'd0, m} * {32'd0, frac} + 48'h8000;
        off  = prod[47:16];
        s    = d[32] ? ({core[31], core} - {1'b0, off}) : ({core[31], core} + {1'b0, off});
        return s[31:0];
    endfunction

    function automatic logic [63:0] f_satadd(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic logic [31:0] f_chg(logic [31:0] q, logic [30:0] st);
        logic [32:0] d;
        d = {q[31], q} - {2'b00, st};
        return (d[32:31] == 2'b10) ? 32'h8000_0000 : d[31:0];
    endfunction

    // memories
    t_atom         mem_atom [MAX_ATOMS];
    logic [31:0]   mem_q    [MAX_ATOMS];
    logic          mem_inq  [MAX_ATOMS];
    logic [AW-1:0] mem_core [MAX_ATOMS];
    t_hyd          mem_hyd  [MAX_HYDROGENS];

    t_atom         r_atom_rd;
    logic [31:0]   r_q_rd;
    logic          r_inq_rd;
    logic [AW-1:0] r_core_rd;
    t_hyd          r_hyd_rd;

    logic [AW-1:0] atom_ra, atom_wa, q_wa, inq_wa, core_ra, core_wa, core_wd;
    logic [HW-1:0] hyd_ra, hyd_wa;
    logic          atom_we, q_we, inq_we, core_we, hyd_we, inq_wd;
    t_atom         atom_wd;
    t_hyd          hyd_wd;
    logic [31:0]   q_wd;

    // control and config
    t_state         r_state;
    t_phase         r_phase;
    logic           r_reduce;
    logic [30:0]    r_cutoff;
    logic [15:0]    r_frac;
    logic [30:0]    r_cstep;
    logic [CW-1:0]  r_acnt, r_ccnt, r_base, r_oscan, r_i, r_j;
    logic [HCW-1:0] r_hcnt;
    logic [EW-1:0]  r_ep;
    logic           r_drop, r_pass3;
    logic [61:0]    r_c2;
    logic [AW-1:0]  r_c, r_eidx;
    logic [31:0]    r_cx, r_cy, r_cz, r_px, r_py, r_pz, r_pq;
    logic [31:0]    r_mx, r_my, r_mz;
    logic [1:0]     r_ax;
    logic [63:0]    r_sq, r_acc;

    logic [AW-1:0]  ld_addr;
    logic           ld_room, hroom, hit, cand;
    logic [EW-1:0]  hoff, total;
    logic [31:0]    sq_m;

    logic           em_go;
    logic [1:0]     em_kind;
    logic [AW-1:0]  em_idx;
    logic [31:0]    em_x, em_y, em_z, em_q, em_idx32;

    assign busy    = (r_state != S_IDLE);
    assign ld_addr = (r_phase != PH_LOAD) ? '0 : r_acnt[AW-1:0];
    assign ld_room = (r_phase != PH_LOAD) || (r_acnt < CW'(MAX_ATOMS));
    assign hroom   = r_hcnt < HCW'(MAX_HYDROGENS);
    assign hit     = r_acc < {2'b00, r_c2};
    assign hoff    = r_ep - EW'(r_ccnt);
    assign total   = EW'(r_acnt) + EW'(r_hcnt);
    assign cand    = !r_atom_rd.core && !r_inq_rd &&
                     (r_pass3 ? r_atom_rd.part : r_atom_rd.bnd);
    assign sq_m    = (r_ax == 2'd0) ? r_mx : ((r_ax == 2'd1) ? r_my : r_mz);
    assign em_idx32 = 32'(em_idx);

    always_comb begin
        atom_ra = r_j[AW-1:0];
        core_ra = r_i[AW-1:0];
        hyd_ra  = hoff[HW-1:0];
        atom_we = 1'b0;
        atom_wa = ld_addr;
        atom_wd = {i_item.in_core, i_item.is_boundary, i_item.is_partner,
                   i_item.pos_x, i_item.pos_y, i_item.pos_z};
        q_we    = 1'b0;
        q_wa    = ld_addr;
        q_wd    = i_item.charge_in;
        inq_we  = 1'b0;
        inq_wa  = r_i[AW-1:0];
        inq_wd  = r_atom_rd.core;
        core_we = 1'b0;
        core_wa = r_ccnt[AW-1:0];
        core_wd = r_i[AW-1:0];
        hyd_we  = 1'b0;
        hyd_wa  = r_hcnt[HW-1:0];
        hyd_wd  = {r_c, f_place(r_cx, r_px, r_frac), f_place(r_cy, r_py, r_frac),
                   f_place(r_cz, r_pz, r_frac)};
        em_go   = 1'b0;
        em_kind = lacp_pkg::REC_CORE;
        em_idx  = r_eidx;
        em_x    = r_atom_rd.x;
        em_y    = r_atom_rd.y;
        em_z    = r_atom_rd.z;
        em_q    = '0;
        case (r_state)
            S_IDLE: begin
                if (start && i_item.kind == lacp_pkg::KIND_LOAD && ld_room) begin
                    atom_we = 1'b1;
                    q_we    = 1'b1;
                end
            end
            S_P1_RD: atom_ra = r_i[AW-1:0];
            S_P1_WR: begin
                inq_we  = 1'b1;
                core_we = r_atom_rd.core;
            end
            S_O_C: atom_ra = r_core_rd;
            S_CMP: begin
                if (hit && !r_pass3) begin
                    inq_we  = 1'b1;
                    inq_wa  = r_j[AW-1:0];
                    inq_wd  = 1'b1;
                    core_we = 1'b1;
                    core_wd = r_j[AW-1:0];
                end
            end
            S_PLACE: begin
                hyd_we = hroom;
                q_we   = r_reduce;
                q_wa   = r_j[AW-1:0];
                q_wd   = f_chg(r_pq, r_cstep);
            end
            S_E_START: core_ra = r_ep[AW-1:0];
            S_E_C1: atom_ra = r_core_rd;
            S_E_C2: em_go = 1'b1;
            S_E_H: begin
                em_go   = 1'b1;
                em_kind = lacp_pkg::REC_HYD;
                em_idx  = r_hyd_rd.owner;
                em_x    = r_hyd_rd.x;
                em_y    = r_hyd_rd.y;
                em_z    = r_hyd_rd.z;
            end
            S_E_SR: atom_ra = r_oscan[AW-1:0];
            S_E_SC: begin
                if (!r_inq_rd) begin
                    em_go   = 1'b1;
                    em_kind = lacp_pkg::REC_OUTER;
                    em_idx  = r_oscan[AW-1:0];
                    em_q    = r_q_rd;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (atom_we) mem_atom[atom_wa] <= atom_wd;
        r_atom_rd <= mem_atom[atom_ra];
    end

    always_ff @(posedge i_clk) begin
        if (q_we) mem_q[q_wa] <= q_wd;
        r_q_rd <= mem_q[atom_ra];
    end

    always_ff @(posedge i_clk) begin
        if (inq_we) mem_inq[inq_wa] <= inq_wd;
        r_inq_rd <= mem_inq[atom_ra];
    end

    always_ff @(posedge i_clk) begin
        if (core_we) mem_core[core_wa] <= core_wd;
        r_core_rd <= mem_core[core_ra];
    end

    always_ff @(posedge i_clk) begin
        if (hyd_we) mem_hyd[hyd_wa] <= hyd_wd;
        r_hyd_rd <= mem_hyd[hyd_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_LOAD;
            r_reduce <= lacp_pkg::RESET_REDUCE;
            r_cutoff <= lacp_pkg::RESET_CUTOFF;
            r_frac   <= lacp_pkg::RESET_FRACTION;
            r_cstep  <= lacp_pkg::RESET_CSTEP;
            r_acnt   <= '0;
            r_ccnt   <= '0;
            r_hcnt   <= '0;
            r_ep     <= '0;
            r_oscan  <= '0;
            r_drop   <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    lacp_pkg::CFG_REDUCE:   r_reduce <= i_cfg_data[0];
                    lacp_pkg::CFG_CUTOFF:   r_cutoff <= i_cfg_data[30:0];
                    lacp_pkg::CFG_FRACTION: r_frac   <= i_cfg_data[15:0];
                    lacp_pkg::CFG_CSTEP:    r_cstep  <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
            if (em_go) begin
                o_strobe                     <= 1'b1;
                o_result.record_kind         <= em_kind;
                o_result.atom_index          <= em_idx32[lacp_pkg::IDX_W-1:0];
                o_result.out_x               <= em_x;
                o_result.out_y               <= em_y;
                o_result.out_z               <= em_z;
                o_result.out_charge          <= em_q;
                o_result.last_record         <= (r_ep + EW'(1)) >= total;
                o_result.hydrogen_dropped    <= r_drop;
                r_ep                         <= r_ep + EW'(1);
                if ((r_ep + EW'(1)) >= total) r_phase <= PH_DONE;
            end
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        if (i_item.kind == lacp_pkg::KIND_LOAD) begin
                            if (r_phase != PH_LOAD) begin
                                // new job
                                r_acnt  <= CW'(1);
                                r_ccnt  <= '0;
                                r_hcnt  <= '0;
                                r_ep    <= '0;
                                r_oscan <= '0;
                                r_drop  <= 1'b0;
                            end else if (ld_room) begin
                                r_acnt <= r_acnt + CW'(1);
                            end
                            r_phase <= i_item.last_atom ? PH_READY : PH_LOAD;
                        end else if (r_phase == PH_READY) begin
                            r_c2    <= {31'd0, r_cutoff} * {31'd0, r_cutoff};
                            r_i     <= '0;
                            r_ccnt  <= '0;
                            r_hcnt  <= '0;
                            r_state <= S_P1_RD;
                        end else if (r_phase == PH_EMIT) begin
                            r_state <= S_E_START;
                        end
                    end
                end
                S_P1_RD: r_state <= S_P1_WR;
                S_P1_WR: begin
                    if (r_atom_rd.core) r_ccnt <= r_ccnt + CW'(1);
                    if (r_i + CW'(1) == r_acnt) begin
                        r_i     <= '0;
                        r_base  <= r_ccnt + CW'(r_atom_rd.core);
                        r_pass3 <= !r_reduce;
                        r_state <= S_O_START;
                    end else begin
                        r_i     <= r_i + CW'(1);
                        r_state <= S_P1_RD;
                    end
                end
                S_O_START: begin
                    if (r_i == (r_pass3 ? r_ccnt : r_base)) begin
                        if (!r_pass3) begin
                            r_pass3 <= 1'b1;
                            r_i     <= '0;
                        end else begin
                            r_phase <= PH_EMIT;
                            r_ep    <= '0;
                            r_oscan <= '0;
                            r_state <= S_E_START;
                        end
                    end else begin
                        r_state <= S_O_RD;
                    end
                end
                S_O_RD: r_state <= S_O_C;
                S_O_C: begin
                    r_c     <= r_core_rd;
                    r_state <= S_O_CD;
                end
                S_O_CD: begin
                    r_cx <= r_atom_rd.x;
                    r_cy <= r_atom_rd.y;
                    r_cz <= r_atom_rd.z;
                    // absorbers are non-boundary, hydrogen owners are boundary
                    if (r_pass3 != r_atom_rd.bnd) begin
                        r_i     <= r_i + CW'(1);
                        r_state <= S_O_START;
                    end else begin
                        r_j     <= '0;
                        r_state <= S_I_RD;
                    end
                end
                S_I_RD: r_state <= S_I_CHK;
                S_I_CHK: begin
                    r_px  <= r_atom_rd.x;
                    r_py  <= r_atom_rd.y;
                    r_pz  <= r_atom_rd.z;
                    r_pq  <= r_q_rd;
                    r_mx  <= f_absdiff(r_cx, r_atom_rd.x);
                    r_my  <= f_absdiff(r_cy, r_atom_rd.y);
                    r_mz  <= f_absdiff(r_cz, r_atom_rd.z);
                    r_acc <= '0;
                    r_ax  <= 2'd0;
                    r_state <= cand ? S_SQ : S_NEXT;
                end
                S_SQ: begin
                    r_sq    <= {32'd0, sq_m} * {32'd0, sq_m};
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc <= f_satadd(r_acc, r_sq);
                    if (r_ax == 2'd2) begin
                        r_state <= S_CMP;
                    end else begin
                        r_ax    <= r_ax + 2'd1;
                        r_state <= S_SQ;
                    end
                end
                S_CMP: begin
                    if (hit && !r_pass3) begin
                        r_ccnt  <= r_ccnt + CW'(1);
                        r_state <= S_NEXT;
                    end else if (hit) begin
                        r_state <= S_PLACE;
                    end else begin
                        r_state <= S_NEXT;
                    end
                end
                S_PLACE: begin
                    if (hroom) r_hcnt <= r_hcnt + HCW'(1);
                    else       r_drop <= 1'b1;
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    r_j <= r_j + CW'(1);
                    if (r_j + CW'(1) == r_acnt) begin
                        r_i     <= r_i + CW'(1);
                        r_state <= S_O_START;
                    end else begin
                        r_state <= S_I_RD;
                    end
                end
                S_E_START: begin
                    if (r_ep < EW'(r_ccnt)) begin
                        r_state <= S_E_C1;
                    end else if (r_ep < total - EW'(r_acnt) + EW'(r_ccnt)) begin
                        r_state <= S_E_H;
                    end else begin
                        r_state <= S_E_SR;
                    end
                end
                S_E_C1: begin
                    r_eidx  <= r_core_rd;
                    r_state <= S_E_C2;
                end
                S_E_C2: r_state <= S_IDLE;
                S_E_H:  r_state <= S_IDLE;
                S_E_SR: begin
                    if (r_oscan >= r_acnt) begin
                        r_phase <= PH_DONE;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_E_SC;
                    end
                end
                S_E_SC: begin
                    r_oscan <= r_oscan + CW'(1);
                    r_state <= r_inq_rd ? S_E_SR : S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- src/lacp_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lacp_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input lacp_pkg::t_in  i_item,
    input logic           o_strobe,
    input lacp_pkg::t_out o_result
);

    logic load_acc;
    assign load_acc = start && !busy && (i_item.kind == lacp_pkg::KIND_LOAD);

    // a record only ends a busy stretch
    `LACP_ASSERT_NOW(a_strobe_after_busy, i_clk, i_rst_n, o_strobe, $past(busy))
    // loads never produce a record
    `LACP_ASSERT_NEXT(a_load_silent, i_clk, i_rst_n, load_acc, !o_strobe)
    // records are spaced by at least one fetch turnaround
    `LACP_ASSERT_NEXT(a_no_strobe_burst, i_clk, i_rst_n, o_strobe, !o_strobe)
    // only outer atoms carry charge
    `LACP_ASSERT_NOW(a_charge_outer_only, i_clk, i_rst_n,
        o_strobe && (o_result.record_kind != lacp_pkg::REC_OUTER),
        o_result.out_charge == 32'sd0)

endmodule

bind link_atom_cutoff_placer lacp_checker u_lacp_checker (.*);

// ----- test/link_atom_cutoff_placer_tb.sv -----
`timescale 1ns / 1ps

module link_atom_cutoff_placer_tb;

    localparam int NATOM = lacp_pkg::MAX_ATOMS_DEF;
    localparam int NHYD  = lacp_pkg::MAX_HYDROGENS_DEF;

    // per-atom flag bits
    localparam logic [3:0] FL_CORE = 4'd1;
    localparam logic [3:0] FL_BND  = 4'd2;
    localparam logic [3:0] FL_PART = 4'd4;
    localparam logic [3:0] FL_INQ  = 4'd8;

    typedef enum int {ST_LOAD, ST_READY, ST_EMIT, ST_DONE} t_stage;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   start = 1'b0;
    logic   busy;
    lacp_pkg::t_in i_item = '0;
    logic   i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = '0;
    logic [lacp_pkg::CFG_W-1:0] i_cfg_data = '0;
    logic   o_strobe;
    lacp_pkg::t_out o_result;

    link_atom_cutoff_placer uut (.*);

    always #2 i_clk = ~i_clk;

    // placer model state
    logic        m_reduce;
    logic [30:0] m_cutoff, m_cstep;
    logic [15:0] m_frac;
    logic signed [31:0] at_x[NATOM], at_y[NATOM], at_z[NATOM], at_q[NATOM];
    logic [3:0]  at_fl[NATOM];
    int          core_ids[NATOM];
    logic signed [31:0] hy_x[NHYD], hy_y[NHYD], hy_z[NHYD];
    int          hy_own[NHYD];
    int          n_atoms, n_core, n_hyd, emit_ptr, outer_ptr;
    logic        dropped;
    t_stage      stage;

    lacp_pkg::t_out pending_records[$];
    int          n_errors = 0;
    int          n_items = 0;
    bit          no_gaps = 0;

    function automatic logic [63:0] dist_sq(int i, int j);
        logic [64:0] acc;
        logic [63:0] m;
        longint d;
        acc = '0;
        for (int a = 0; a < 3; a++) begin
            case (a)
                0: d = longint'(at_x[i]) - longint'(at_x[j]);
                1: d = longint'(at_y[i]) - longint'(at_y[j]);
                default: d = longint'(at_z[i]) - longint'(at_z[j]);
            endcase
            m = (d < 0) ? 64'(-d) : 64'(d);
            acc = acc + {1'b0, m * m};
            if (acc[64]) acc = {1'b0, {64{1'b1}}};
        end
        return acc[63:0];
    endfunction

    function automatic logic signed [31:0] place_h(logic signed [31:0] c, logic signed [31:0] p);
        longint d, off;
        logic [63:0] m;
        d = longint'(p) - longint'(c);
        m = (d < 0) ? 64'(-d) : 64'(d);
        off = longint'((m * m_frac + 64'h8000) >> 16);
        return 32'(longint'(c) + ((d < 0) ? -off : off));
    endfunction

    task automatic neighbor_pass();
        logic [63:0] c2;
        longint q;
        int c, base;
        c2 = 64'(m_cutoff) * 64'(m_cutoff);
        n_core = 0;
        for (int i = 0; i < n_atoms; i++) begin
            if (at_fl[i] & FL_CORE) begin
                at_fl[i] |= FL_INQ;
                core_ids[n_core++] = i;
            end else at_fl[i] &= ~FL_INQ;
        end
        if (m_reduce) begin
            base = n_core;
            for (int i = 0; i < base; i++) begin
                c = core_ids[i];
                if (at_fl[c] & FL_BND) continue;
                for (int j = 0; j < n_atoms; j++) begin
                    if ((at_fl[j] & (FL_CORE | FL_INQ | FL_BND)) != FL_BND) continue;
                    if (dist_sq(c, j) < c2) begin
                        at_fl[j] |= FL_INQ;
                        core_ids[n_core++] = j;
                    end
                end
            end
        end
        n_hyd = 0;
        for (int i = 0; i < n_core; i++) begin
            c = core_ids[i];
            if (!(at_fl[c] & FL_BND)) continue;
            for (int j = 0; j < n_atoms; j++) begin
                if (at_fl[j] & (FL_CORE | FL_INQ)) continue;
                if (!(at_fl[j] & FL_PART)) continue;
                if (!(dist_sq(c, j) < c2)) continue;
                if (n_hyd < NHYD) begin
                    hy_x[n_hyd] = place_h(at_x[c], at_x[j]);
                    hy_y[n_hyd] = place_h(at_y[c], at_y[j]);
                    hy_z[n_hyd] = place_h(at_z[c], at_z[j]);
                    hy_own[n_hyd] = c;
                    n_hyd++;
                end else dropped = 1'b1;
                if (m_reduce) begin
                    q = longint'(at_q[j]) - longint'(m_cstep);
                    if (q < -64'sd2147483648) q = -64'sd2147483648;
                    at_q[j] = 32'(q);
                end
            end
        end
        emit_ptr = 0;
        outer_ptr = 0;
        stage = ST_EMIT;
    endtask

    task automatic placer_step(lacp_pkg::t_in it);
        lacp_pkg::t_out r;
        int idx;
        r = '0;
        if (it.kind == lacp_pkg::KIND_LOAD) begin
            if (stage != ST_LOAD) begin
                n_atoms = 0; n_core = 0; n_hyd = 0;
                emit_ptr = 0; outer_ptr = 0; dropped = 0;
                stage = ST_LOAD;
            end
            if (n_atoms < NATOM) begin
                at_x[n_atoms] = it.pos_x;
                at_y[n_atoms] = it.pos_y;
                at_z[n_atoms] = it.pos_z;
                at_q[n_atoms] = it.charge_in;
                at_fl[n_atoms] = (it.in_core ? FL_CORE : 4'd0) |
                                 (it.is_boundary ? FL_BND : 4'd0) |
                                 (it.is_partner ? FL_PART : 4'd0);
                n_atoms++;
            end
            if (it.last_atom) stage = ST_READY;
            return;
        end
        if (stage == ST_READY) neighbor_pass();
        if (stage != ST_EMIT) return;
        if (emit_ptr < n_core) begin
            idx = core_ids[emit_ptr];
            r.record_kind = lacp_pkg::REC_CORE;
            r.out_x = at_x[idx]; r.out_y = at_y[idx]; r.out_z = at_z[idx];
        end else if (emit_ptr < n_core + n_hyd) begin
            idx = hy_own[emit_ptr - n_core];
            r.record_kind = lacp_pkg::REC_HYD;
            r.out_x = hy_x[emit_ptr - n_core];
            r.out_y = hy_y[emit_ptr - n_core];
            r.out_z = hy_z[emit_ptr - n_core];
        end else begin
            while (outer_ptr < n_atoms && (at_fl[outer_ptr] & FL_INQ)) outer_ptr++;
            if (outer_ptr >= n_atoms) begin
                stage = ST_DONE;
                return;
            end
            idx = outer_ptr++;
            r.record_kind = lacp_pkg::REC_OUTER;
            r.out_x = at_x[idx]; r.out_y = at_y[idx]; r.out_z = at_z[idx];
            r.out_charge = at_q[idx];
        end
        r.atom_index = idx[lacp_pkg::IDX_W-1:0];
        emit_ptr++;
        r.last_record = (emit_ptr >= n_atoms + n_hyd);
        r.hydrogen_dropped = dropped;
        if (r.last_record) stage = ST_DONE;
        pending_records.push_back(r);
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        n_errors++;
        $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
    endtask

    // result checker
    always @(posedge i_clk) begin
        lacp_pkg::t_out w;
        if (i_rst_n && o_strobe) begin
            if (pending_records.size() == 0) begin
                report_mismatch("unexpected record", 64'(o_result), 64'd0);
            end else begin
                w = pending_records.pop_front();
                if (o_result.record_kind !== w.record_kind)
                    report_mismatch("record_kind", 64'(o_result.record_kind),
                                    64'(w.record_kind));
                if (o_result.atom_index !== w.atom_index)
                    report_mismatch("atom_index", 64'(o_result.atom_index),
                                    64'(w.atom_index));
                if (o_result.out_x !== w.out_x)
                    report_mismatch("out_x", 64'(o_result.out_x), 64'(w.out_x));
                if (o_result.out_y !== w.out_y)
                    report_mismatch("out_y", 64'(o_result.out_y), 64'(w.out_y));
                if (o_result.out_z !== w.out_z)
                    report_mismatch("out_z", 64'(o_result.out_z), 64'(w.out_z));
                if (o_result.out_charge !== w.out_charge)
                    report_mismatch("out_charge", 64'(o_result.out_charge),
                                    64'(w.out_charge));
                if (o_result.last_record !== w.last_record)
                    report_mismatch("last_record", 64'(o_result.last_record),
                                    64'(w.last_record));
                if (o_result.hydrogen_dropped !== w.hydrogen_dropped)
                    report_mismatch("hydrogen_dropped", 64'(o_result.hydrogen_dropped),
                                    64'(w.hydrogen_dropped));
            end
        end
    end

    task automatic send_item(lacp_pkg::t_in it);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start = 1'b1;
        i_item = it;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        placer_step(it);
        n_items++;
        @(negedge i_clk);
        start = 1'b0;
    endtask

    task automatic send_atom(bit core, bit bnd, bit part, logic signed [31:0] x,
                             logic signed [31:0] y, logic signed [31:0] z,
                             logic signed [31:0] q, bit last);
        lacp_pkg::t_in it;
        it = '{kind: lacp_pkg::KIND_LOAD, in_core: core, is_boundary: bnd, is_partner: part,
               pos_x: x, pos_y: y, pos_z: z, charge_in: q, last_atom: last};
        send_item(it);
    endtask

    // fetch with random junk in the unused fields
    task automatic send_fetch();
        lacp_pkg::t_in it;
        logic [159:0] junk;
        junk = {$urandom, $urandom, $urandom, $urandom, $urandom};
        it = junk[$bits(lacp_pkg::t_in)-1:0];
        it.kind = lacp_pkg::KIND_FETCH;
        send_item(it);
    endtask

    task automatic drain_job(int extra);
        while (stage == ST_EMIT || stage == ST_READY) send_fetch();
        repeat (extra) send_fetch();
    endtask

    task automatic wait_idle();
        while (pending_records.size() != 0) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [30:0] val);
        wait_idle();
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            lacp_pkg::CFG_REDUCE:   m_reduce = val[0];
            lacp_pkg::CFG_CUTOFF:   m_cutoff = val;
            lacp_pkg::CFG_FRACTION: m_frac = val[15:0];
            default:                m_cstep = val;
        endcase
    endtask

    function automatic logic signed [31:0] near(logic signed [31:0] c, int spread);
        return c + $signed($urandom_range(0, 2 * spread)) - spread;
    endfunction

    task automatic test_defaults();
        send_fetch();                                  // fetch while loading
        send_atom(1, 0, 0, 32'sh10000, 0, 0, 32'sh1234, 0);
        send_atom(1, 1, 0, 0, 0, 0, 32'sh5, 0);
        send_atom(0, 0, 1, 32'sh8000, 32'sh8000, 32'sh8000, 32'sh20000, 0);
        send_atom(0, 0, 1, -32'sh18000, 32'sh10000, 0, -32'sh4000, 0);
        send_atom(0, 1, 0, 32'sh10000, 32'sh10000, 0, 32'sh7, 0);
        send_atom(0, 0, 1, 32'sh40000, 0, 0, 32'sh99, 1);      // outside cutoff
        drain_job(2);                                  // fetches past the end
    endtask

    task automatic test_reduce();
        write_reg(lacp_pkg::CFG_REDUCE, 31'd1);
        write_reg(lacp_pkg::CFG_CSTEP, 31'h7FFFFFFF);
        send_atom(1, 0, 0, 0, 0, 0, 0, 0);
        send_atom(0, 1, 0, 32'sh10000, 0, 0, 0, 0);    // absorbed boundary atom
        send_atom(0, 0, 1, 32'sh20000, 32'sh8000, 0, 32'sh80000000, 0);
        send_atom(0, 0, 1, 32'sh28000, 0, 0, 32'sh7FFFFFFF, 0);
        send_atom(0, 1, 1, 32'sh50000, 0, 0, 32'sh100, 1);  // boundary out of reach
        drain_job(1);
    endtask

    task automatic test_extremes();
        write_reg(lacp_pkg::CFG_CUTOFF, 31'h7FFFFFFF);
        write_reg(lacp_pkg::CFG_FRACTION, 31'h0FFFF);
        send_atom(1, 1, 0, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 0, 0);
        send_atom(0, 0, 1, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 1, 0);
        send_atom(0, 0, 1, 32'sh7FFF0000, 32'sh80001000, 32'sh7FFFFFFF, -1, 1);
        drain_job(0);
        write_reg(lacp_pkg::CFG_FRACTION, 31'd0);
        write_reg(lacp_pkg::CFG_CUTOFF, 31'd0);        // nothing is in range
        send_atom(1, 1, 0, 0, 0, 0, 0, 0);
        send_atom(0, 0, 1, 0, 0, 0, 32'sh55, 1);
        drain_job(0);
    endtask

    task automatic test_restart();
        write_reg(lacp_pkg::CFG_CUTOFF, lacp_pkg::RESET_CUTOFF);
        write_reg(lacp_pkg::CFG_FRACTION, 31'(lacp_pkg::RESET_FRACTION));
        write_reg(lacp_pkg::CFG_CSTEP, lacp_pkg::RESET_CSTEP);
        send_atom(1, 1, 0, 0, 0, 0, 0, 0);
        send_atom(0, 0, 1, 32'sh10000, 0, 0, 32'sh30000, 1);
        send_atom(0, 0, 1, 0, 32'sh10000, 0, 32'sh1, 1);   // load while ready
        send_fetch();
        send_atom(1, 0, 0, 5, 6, 7, 8, 1);             // load after the last record
        drain_job(1);
    endtask

    task automatic test_atom_store_full();
        write_reg(lacp_pkg::CFG_REDUCE, 31'd0);
        no_gaps = 1;
        for (int i = 0; i < NATOM + 6; i++)
            send_atom(i >= NATOM - 1, 0, 0, $urandom, $urandom, $urandom, $urandom,
                      i == NATOM + 5);
        send_fetch();
        send_fetch();
        send_fetch();
        no_gaps = 0;
    endtask

    task automatic test_hydrogen_store_full();
        no_gaps = 1;
        for (int i = 0; i < 33; i++) send_atom(1, 1, 0, i, 0, 0, 0, 0);
        for (int i = 0; i < 32; i++) send_atom(0, 0, 1, 0, i * 64, 0, i, i == 31);
        repeat (40) send_fetch();
        no_gaps = 0;
        send_atom(1, 0, 0, 0, 0, 0, 0, 1);             // fresh job clears drop flag
        drain_job(0);
    endtask

    task automatic test_random();
        int n;
        logic signed [31:0] bx, by, bz;
        while (n_items < 1450) begin
            if ($urandom_range(0, 5) == 0) begin
                wait_idle();
                case ($urandom_range(0, 3))
                    0: write_reg(lacp_pkg::CFG_REDUCE, 31'($urandom));
                    1: write_reg(lacp_pkg::CFG_CUTOFF,
                                 31'(($urandom_range(0, 7) == 0) ? $urandom :
                                     $urandom_range(0, 400000)));
                    2: write_reg(lacp_pkg::CFG_FRACTION, 31'($urandom));
                    default: write_reg(lacp_pkg::CFG_CSTEP,
                                       31'(($urandom_range(0, 3) == 0) ? $urandom :
                                           $urandom_range(0, 100000)));
                endcase
            end
            if ($urandom_range(0, 3) == 0) no_gaps = !no_gaps;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 16);
            bx = $urandom; by = $urandom; bz = $urandom;
            if ($urandom_range(0, 7) == 0) send_fetch();
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 9) == 0)
                    send_atom(1'($urandom), 1'($urandom), 1'($urandom), $urandom, $urandom,
                              $urandom, $urandom, i == n - 1);
                else
                    send_atom($urandom_range(0, 3) == 0, 1'($urandom), 1'($urandom),
                              near(bx, 200000), near(by, 200000), near(bz, 200000),
                              $urandom, i == n - 1);
            end
            // sometimes cut the emission short with the next load
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(0, 4)) send_fetch();
            else
                drain_job($urandom_range(0, 1));
        end
    endtask

    initial begin
        m_reduce = lacp_pkg::RESET_REDUCE;
        m_cutoff = lacp_pkg::RESET_CUTOFF;
        m_frac = lacp_pkg::RESET_FRACTION;
        m_cstep = lacp_pkg::RESET_CSTEP;
        n_atoms = 0; n_core = 0; n_hyd = 0; emit_ptr = 0; outer_ptr = 0;
        dropped = 0;
        stage = ST_LOAD;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_defaults();
        test_reduce();
        test_extremes();
        test_restart();
        test_atom_store_full();
        test_hydrogen_store_full();
        test_random();
        while (pending_records.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (n_errors == 0)
            $display("** link_atom_cutoff_placer: PASSED **");
        else
            $display("** link_atom_cutoff_placer: FAILED **");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("** link_atom_cutoff_placer: FAILED **");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+src
src/lacp_pkg.sv
src/link_atom_cutoff_placer.sv
src/lacp_checker.sv
test/link_atom_cutoff_placer_tb.sv
